// File: rtl/assert_macros.svh
// Assertion macros shared by the particle advect and deposit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define PAD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the default clock and reset of this project.
`define PAD_ASSERT(label, prop, msg) \
  `PAD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/pad_pkg.sv
// Types, codes and constants of the particle advect and deposit block.
package pad_pkg;

  // Field widths.
  localparam int unsigned POS_W      = 40;
  localparam int unsigned VEL_W      = 24;
  localparam int unsigned CS_W       = 32;
  localparam int unsigned TS_W       = 24;
  localparam int unsigned MASS_W     = 32;
  localparam int unsigned MAPV_W     = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  // Quotient bits of the cell divider: covers grid sizes up to 1024.
  localparam int unsigned QW  = 10;
  localparam int unsigned QCW = 4;

  // Function codes.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_PUSH  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  // Velocity components; the last code selects no field.
  localparam logic [1:0] COMP_X    = 2'd0;
  localparam logic [1:0] COMP_Y    = 2'd1;
  localparam logic [1:0] COMP_Z    = 2'd2;
  localparam logic [1:0] COMP_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd6;

  // Input word.
  typedef struct packed {
    logic        [1:0]  func;
    logic        [1:0]  component;
    logic        [5:0]  index_i;
    logic        [5:0]  index_j;
    logic        [4:0]  index_k;
    logic signed [23:0] value;
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] pos_z;
    logic        [31:0] mass;
    logic        [22:0] settle_speed;
  } pad_in_t;

  // Result word.
  typedef struct packed {
    logic signed [39:0] new_x;
    logic signed [39:0] new_y;
    logic signed [39:0] new_z;
    logic               deposited;
    logic        [47:0] map_value;
  } pad_out_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [39:0] dividend;
    logic [31:0] divisor;
  } pad_div_req_t;

  typedef struct packed {
    logic          done;
    logic          ovf;
    logic [QW-1:0] quot;
  } pad_div_rsp_t;

  // Sequencer states.
  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DGO   = 13'b0000000000100,
    S_DWAIT = 13'b0000000001000,
    S_RDA   = 13'b0000000010000,
    S_RDB   = 13'b0000000100000,
    S_SUM   = 13'b0000001000000,
    S_MUL   = 13'b0000010000000,
    S_ACC   = 13'b0000100000000,
    S_POS   = 13'b0001000000000,
    S_MRD   = 13'b0010000000000,
    S_MUPD  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } pad_state_e;

endpackage

// File: rtl/pad_div.sv
// Restoring divider that gives a cell quotient and an overflow flag, one bit per cycle.
`include "assert_macros.svh"

module pad_div import pad_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pad_div_req_t req_i,
  output pad_div_rsp_t rsp_o
);

  logic             busy_q;
  logic             done_q;
  logic             ovf_q;
  logic [QCW-1:0]   cnt_q;
  logic [39:0]      rem_q;
  logic [QW+31:0]   dsh_q;
  logic [QW-1:0]    quot_q;
  logic             ge;

  // Compare the remainder with the shifted divisor.
  assign ge = {2'b00, rem_q} >= dsh_q;

  // Control: start, step, finish.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= QCW'(QW);
      end else if (busy_q) begin
        if ((cnt_q == QCW'(QW) && ge) || cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Datapath: subtract and shift in quotient bits.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.dividend;
      dsh_q  <= {req_i.divisor, {QW{1'b0}}};
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      if (cnt_q == QCW'(QW) && ge) begin
        ovf_q <= 1'b1;
      end else begin
        if (ge) begin
          rem_q <= rem_q - dsh_q[39:0];
        end
        quot_q <= {quot_q[QW-2:0], ge};
        dsh_q  <= dsh_q >> 1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = quot_q;

  `PAD_ASSERT(a_div_start_busy, req_i.start |=> busy_q, "divider not busy after start")
  `PAD_ASSERT(a_div_done_idle, done_q |-> !busy_q && !$past(req_i.start), "divider done while busy")

endmodule

// File: rtl/particle_advect_deposit.sv
// Top level: particle advect and deposit sequencer, field and map memories.
//
//   channel | dir | handshake                  | word
//   --------+-----+----------------------------+-----------
//   in      | in  | in_valid_i / in_stall_o    | pad_in_t
//   out     | out | out_valid_o / out_stall_i  | pad_out_t
//   cfg     | in  | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// A particle passes three cell divisions on the one shared restoring divider (each cut
// short when the quotient overflows), then field reads, three products on one multiplier
// and, on a deposit, a map read-modify-write. A velocity write goes straight to the output
// state; a map read first reads the map.
// After reset the deposit map is cleared, one entry a cycle, with in_stall_o high.
// A result waits in the output register while out_stall_i is high; the next word is
// taken meanwhile and held at its end until the register frees.
`include "assert_macros.svh"

module particle_advect_deposit import pad_pkg::*; #(
  parameter int GRID_NX = 64,
  parameter int GRID_NY = 64,
  parameter int GRID_NZ = 32,
  parameter int MAP_NX  = 64,
  parameter int MAP_NY  = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pad_in_t               in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pad_out_t              out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int VDEPTH = GRID_NX * GRID_NY * GRID_NZ;
  localparam int VAW    = $clog2(VDEPTH);
  localparam int XW     = $clog2(GRID_NX);
  localparam int YW     = $clog2(GRID_NY);
  localparam int ZW     = $clog2(GRID_NZ);
  localparam int MDEPTH = MAP_NX * MAP_NY;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

  // Configuration registers.
  logic signed [POS_W-1:0] org_x_q, org_y_q, org_z_q;
  logic        [CS_W-1:0]  cs_x_q, cs_y_q, cs_z_q;
  logic        [TS_W-1:0]  ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      cs_x_q  <= 32'd65536;
      cs_y_q  <= 32'd65536;
      cs_z_q  <= 32'd65536;
      ts_q    <= 24'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X:  org_x_q <= cfg_data_i;
        CFG_ORIGIN_Y:  org_y_q <= cfg_data_i;
        CFG_ORIGIN_Z:  org_z_q <= cfg_data_i;
        CFG_CELL_X:    cs_x_q  <= cfg_data_i[CS_W-1:0];
        CFG_CELL_Y:    cs_y_q  <= cfg_data_i[CS_W-1:0];
        CFG_CELL_Z:    cs_z_q  <= cfg_data_i[CS_W-1:0];
        CFG_TIME_STEP: ts_q    <= cfg_data_i[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and working registers.
  pad_state_e state_q, state_d;
  logic [1:0] axis_q;
  logic [MAW-1:0] clr_q;
  pad_in_t item_q;
  pad_out_t res_q;
  pad_out_t out_q;
  logic out_valid_q;
  logic [XW-1:0] ci_q;
  logic [YW-1:0] cj_q;
  logic [ZW-1:0] ck_q;
  logic [VEL_W-1:0] vx_lo_q, vy_lo_q, vz_lo_q;
  logic [VEL_W-1:0] vx_rd_q, vy_rd_q, vz_rd_q;
  logic signed [24:0] u2_q, v2_q;
  logic signed [25:0] w2_q;
  logic signed [50:0] prod_q;
  logic signed [40:0] nx_q, ny_q, nz_q;
  logic [MAPV_W-1:0] map_rd_q;

  logic in_acc;
  logic out_free;
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Velocity write address and range check.
  logic [30:0] wa_full;
  logic wr_ok;
  assign wa_full = 31'(in_item_i.index_k) * 31'(GRID_NY * GRID_NX)
                 + 31'(in_item_i.index_j) * 31'(GRID_NX)
                 + 31'(in_item_i.index_i);
  assign wr_ok = in_acc && (in_item_i.func == FUNC_WRITE)
              && (11'(in_item_i.index_i) < 11'(GRID_NX))
              && (11'(in_item_i.index_j) < 11'(GRID_NY))
              && (11'(in_item_i.index_k) < 11'(GRID_NZ));

  // Velocity read addresses: the cell, then its upper neighbor per axis.
  logic [30:0] base_full;
  logic [VAW-1:0] vx_ra, vy_ra, vz_ra;
  assign base_full = 31'(ck_q) * 31'(GRID_NY * GRID_NX) + 31'(cj_q) * 31'(GRID_NX)
                   + 31'(ci_q);
  always_comb begin
    vx_ra = base_full[VAW-1:0];
    vy_ra = base_full[VAW-1:0];
    vz_ra = base_full[VAW-1:0];
    if (state_q == S_RDB) begin
      vx_ra = VAW'(base_full + 31'd1);
      vy_ra = VAW'(base_full + 31'(GRID_NX));
      vz_ra = VAW'(base_full + 31'(GRID_NX * GRID_NY));
    end
  end

  // Velocity field memories.
  logic [VEL_W-1:0] velx_mem [VDEPTH];
  logic [VEL_W-1:0] vely_mem [VDEPTH];
  logic [VEL_W-1:0] velz_mem [VDEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_ok && in_item_i.component == COMP_X) begin
      velx_mem[wa_full[VAW-1:0]] <= in_item_i.value;
    end
    vx_rd_q <= velx_mem[vx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok && in_item_i.component == COMP_Y) begin
      vely_mem[wa_full[VAW-1:0]] <= in_item_i.value;
    end
    vy_rd_q <= vely_mem[vy_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok && in_item_i.component == COMP_Z) begin
      velz_mem[wa_full[VAW-1:0]] <= in_item_i.value;
    end
    vz_rd_q <= velz_mem[vz_ra];
  end

  // Divider operands for the current axis.
  logic signed [POS_W-1:0] pos_sel, org_sel;
  logic [CS_W-1:0] cs_sel;
  logic [QW-1:0] nm1_sel;
  logic [40:0] rel_pos;
  always_comb begin
    unique case (axis_q)
      2'd0: begin
        pos_sel = item_q.pos_x; org_sel = org_x_q; cs_sel = cs_x_q;
        nm1_sel = QW'(GRID_NX - 1);
      end
      2'd1: begin
        pos_sel = item_q.pos_y; org_sel = org_y_q; cs_sel = cs_y_q;
        nm1_sel = QW'(GRID_NY - 1);
      end
      default: begin
        pos_sel = item_q.pos_z; org_sel = org_z_q; cs_sel = cs_z_q;
        nm1_sel = QW'(GRID_NZ - 1);
      end
    endcase
  end
  assign rel_pos = {pos_sel[POS_W-1], pos_sel} - {org_sel[POS_W-1], org_sel};

  pad_div_req_t div_req;
  pad_div_rsp_t div_rsp;
  assign div_req.start    = (state_q == S_DGO);
  assign div_req.dividend = rel_pos[39:0];
  assign div_req.divisor  = (cs_sel == '0) ? 32'd1 : cs_sel;

  pad_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Clamp the quotient to the grid.
  logic [QW-1:0] cell_clamp;
  always_comb begin
    priority if (rel_pos[40]) begin
      cell_clamp = '0;
    end else if (div_rsp.ovf || div_rsp.quot > nm1_sel) begin
      cell_clamp = nm1_sel;
    end else begin
      cell_clamp = div_rsp.quot;
    end
  end

  logic interior;
  assign interior = (ci_q < XW'(GRID_NX - 1)) && (cj_q < YW'(GRID_NY - 1))
                 && (ck_q < ZW'(GRID_NZ - 1));

  // Doubled velocities, settling folded into z.
  logic signed [24:0] u2_d, v2_d, wsum;
  logic signed [25:0] w2_d;
  always_comb begin
    u2_d = '0;
    v2_d = '0;
    wsum = '0;
    if (interior) begin
      u2_d = $signed({vx_lo_q[VEL_W-1], vx_lo_q}) + $signed({vx_rd_q[VEL_W-1], vx_rd_q});
      v2_d = $signed({vy_lo_q[VEL_W-1], vy_lo_q}) + $signed({vy_rd_q[VEL_W-1], vy_rd_q});
      wsum = $signed({vz_lo_q[VEL_W-1], vz_lo_q}) + $signed({vz_rd_q[VEL_W-1], vz_rd_q});
    end
    w2_d = 26'(wsum) - $signed({2'b00, item_q.settle_speed, 1'b0});
  end

  // Shared multiplier and rounding.
  logic signed [25:0] mul_op;
  logic signed [50:0] prod_d;
  logic signed [50:0] prod_rnd;
  logic signed [33:0] disp;
  logic signed [40:0] npos;
  always_comb begin
    unique case (axis_q)
      2'd0:    mul_op = 26'(u2_q);
      2'd1:    mul_op = 26'(v2_q);
      default: mul_op = w2_q;
    endcase
  end
  assign prod_d   = 51'(mul_op) * 51'($signed({1'b0, ts_q}));
  assign prod_rnd = prod_q + 51'sd65536;
  assign disp     = prod_rnd[50:17];
  assign npos     = {pos_sel[POS_W-1], pos_sel} + 41'(disp);

  // Deposit test on the unsaturated z.
  logic signed [43:0] dep_lhs, dep_rhs;
  logic dep;
  assign dep_lhs = {{2{nz_q[40]}}, nz_q, 1'b0};
  assign dep_rhs = $signed({{3{org_z_q[POS_W-1]}}, org_z_q, 1'b0})
                 + $signed({12'b0, cs_z_q});
  assign dep = dep_lhs < dep_rhs;

  function automatic logic [POS_W-1:0] sat40(input logic [40:0] v);
    logic [POS_W-1:0] r;
    r = v[POS_W-1:0];
    if (v[40] != v[39]) begin
      r = v[40] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Deposit map address, clamped to the map.
  logic [10:0] mi, mj;
  logic [20:0] ma_full;
  logic map_in;
  logic [MAW-1:0] map_addr;
  assign mi = (11'(item_q.index_i) < 11'(MAP_NX)) ? 11'(item_q.index_i) : 11'(MAP_NX - 1);
  assign mj = (11'(item_q.index_j) < 11'(MAP_NY)) ? 11'(item_q.index_j) : 11'(MAP_NY - 1);
  assign ma_full = 21'(mj) * 21'(MAP_NX) + 21'(mi);
  assign map_in = (11'(item_q.index_i) < 11'(MAP_NX)) && (11'(item_q.index_j) < 11'(MAP_NY));
  assign map_addr = ma_full[MAW-1:0];

  logic [48:0] map_sum;
  logic [MAPV_W-1:0] map_wd;
  logic map_we;
  logic [MAW-1:0] map_wa;
  assign map_sum = {1'b0, map_rd_q} + 49'(item_q.mass);
  assign map_we  = (state_q == S_CLR)
                || (state_q == S_MUPD && item_q.func == FUNC_PUSH);
  assign map_wa  = (state_q == S_CLR) ? clr_q : map_addr;
  assign map_wd  = (state_q == S_CLR) ? '0
                 : (map_sum[48] ? {MAPV_W{1'b1}} : map_sum[MAPV_W-1:0]);

  // Deposit map memory.
  logic [MAPV_W-1:0] map_mem [MDEPTH];
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd_q <= map_mem[map_addr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (clr_q == MAW'(MDEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_item_i.func)
            FUNC_PUSH: state_d = S_DGO;
            FUNC_READ: state_d = S_MRD;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_DGO:   state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_rsp.done) begin
          state_d = (axis_q != 2'd2) ? S_DGO : S_RDA;
        end
      end
      S_RDA:   state_d = S_RDB;
      S_RDB:   state_d = S_SUM;
      S_SUM:   state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = (axis_q == 2'd2) ? S_POS : S_MUL;
      S_POS:   state_d = dep ? S_MRD : S_OUT;
      S_MRD:   state_d = S_MUPD;
      S_MUPD:  state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if ((state_q == S_DWAIT && div_rsp.done) || state_q == S_ACC) begin
        axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
      res_q  <= '0;
    end
    if (state_q == S_DWAIT && div_rsp.done) begin
      unique case (axis_q)
        2'd0:    ci_q <= cell_clamp[XW-1:0];
        2'd1:    cj_q <= cell_clamp[YW-1:0];
        default: ck_q <= cell_clamp[ZW-1:0];
      endcase
    end
    if (state_q == S_RDB) begin
      vx_lo_q <= vx_rd_q;
      vy_lo_q <= vy_rd_q;
      vz_lo_q <= vz_rd_q;
    end
    if (state_q == S_SUM) begin
      u2_q <= u2_d;
      v2_q <= v2_d;
      w2_q <= w2_d;
    end
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == S_ACC) begin
      unique case (axis_q)
        2'd0:    nx_q <= npos;
        2'd1:    ny_q <= npos;
        default: nz_q <= npos;
      endcase
    end
    if (state_q == S_POS && !dep) begin
      res_q.new_x <= sat40(nx_q);
      res_q.new_y <= sat40(ny_q);
      res_q.new_z <= sat40(nz_q);
    end
    if (state_q == S_MUPD) begin
      if (item_q.func == FUNC_PUSH) begin
        res_q.deposited <= 1'b1;
      end else begin
        res_q.map_value <= map_in ? map_rd_q : '0;
      end
    end
    if (state_q == S_OUT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PAD_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == S_OUT), "result without sequencer")
  `PAD_ASSERT(a_div_done_wait, div_rsp.done |-> state_q == S_DWAIT, "divider result unexpected")
  `PAD_ASSERT(a_map_rmw, map_we && state_q != S_CLR |-> $past(state_q == S_MRD), "map write without read")

endmodule

// File: sim/tb_particle_advect_deposit.sv
// Testbench for particle_advect_deposit: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module tb_particle_advect_deposit;
  import pad_pkg::*;

  localparam int  NX = 64;
  localparam int  NY = 64;
  localparam int  NZ = 32;
  localparam int  MNX = 64;
  localparam int  MNY = 64;
  localparam longint POS_HI = 64'sd549755813887;
  localparam longint POS_LO = -64'sd549755813888;
  localparam longint MAP_SAT = 64'h0000_FFFF_FFFF_FFFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  pad_in_t               in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pad_out_t              out_item_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predictor state: configuration, wind fields and deposit map.
  longint org_x, org_y, org_z, cs_x, cs_y, cs_z, dt;
  logic signed [23:0] wind_x [int];
  logic signed [23:0] wind_y [int];
  logic signed [23:0] wind_z [int];
  longint unsigned dep_map [MNX*MNY];

  pad_in_t  pending_words [$];
  pad_out_t expected_words [$];
  logic     in_taken = 1'b0;
  logic     calm = 1'b0;
  int       errors = 0;

  particle_advect_deposit dut (.*);

  // Clock: 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int wind_addr(int i, int j, int k);
    return (k * NY + j) * NX + i;
  endfunction

  function automatic longint cell_index(longint pos, longint org, longint cs, int n);
    longint d, b, q;
    d = pos - org;
    b = (cs == 0) ? 1 : cs;
    if (d >= 0) q = d / b;
    else q = -((-d + b - 1) / b);
    if (q < 0) q = 0;
    if (q > n - 1) q = n - 1;
    return q;
  endfunction

  function automatic longint step_delta(longint vel2);
    longint t;
    t = vel2 * dt + 65536;
    return t >>> 17;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  // Compute the result of one word and update the predictor state.
  function automatic pad_out_t advance_state(pad_in_t w);
    pad_out_t r;
    longint px, py, pz, ci, cj, ck, u2, v2, w2, nx, ny, nz;
    int a, m, si, sj;
    longint unsigned s;
    r = '0;
    case (w.func)
      FUNC_WRITE: begin
        a = wind_addr(w.index_i, w.index_j, w.index_k);
        if (w.component == COMP_X) wind_x[a] = w.value;
        else if (w.component == COMP_Y) wind_y[a] = w.value;
        else if (w.component == COMP_Z) wind_z[a] = w.value;
      end
      FUNC_PUSH: begin
        px = w.pos_x; py = w.pos_y; pz = w.pos_z;
        ci = cell_index(px, org_x, cs_x, NX);
        cj = cell_index(py, org_y, cs_y, NY);
        ck = cell_index(pz, org_z, cs_z, NZ);
        u2 = 0; v2 = 0; w2 = 0;
        if (ci < NX - 1 && cj < NY - 1 && ck < NZ - 1) begin
          a = wind_addr(ci, cj, ck);
          u2 = longint'(wind_x[a]) + longint'(wind_x[wind_addr(ci + 1, cj, ck)]);
          v2 = longint'(wind_y[a]) + longint'(wind_y[wind_addr(ci, cj + 1, ck)]);
          w2 = longint'(wind_z[a]) + longint'(wind_z[wind_addr(ci, cj, ck + 1)]);
        end
        w2 = w2 - 2 * longint'(w.settle_speed);
        nx = px + step_delta(u2);
        ny = py + step_delta(v2);
        nz = pz + step_delta(w2);
        if (2 * nz < 2 * org_z + cs_z) begin
          si = w.index_i; sj = w.index_j;
          m = sj * MNX + si;
          s = dep_map[m] + w.mass;
          dep_map[m] = (s > MAP_SAT) ? MAP_SAT : s;
          r.deposited = 1'b1;
        end else begin
          r.new_x = 40'(clamp_pos(nx));
          r.new_y = 40'(clamp_pos(ny));
          r.new_z = 40'(clamp_pos(nz));
        end
      end
      FUNC_READ: r.map_value = 48'(dep_map[int'(w.index_j) * MNX + int'(w.index_i)]);
      default: ;
    endcase
    return r;
  endfunction

  // Queue a word and its expected result.
  task automatic issue(pad_in_t w);
    expected_words = {expected_words, advance_state(w)};
    pending_words = {pending_words, w};
  endtask

  function automatic logic signed [23:0] rand_wind();
    if ($urandom_range(3) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(131072)) - 65536);
  endfunction

  // Write any wind sample that the particle's cell would read and that was never written.
  task automatic fill_wind(pad_in_t p);
    longint ci, cj, ck;
    int a, ax, ay, az;
    pad_in_t w;
    ci = cell_index(p.pos_x, org_x, cs_x, NX);
    cj = cell_index(p.pos_y, org_y, cs_y, NY);
    ck = cell_index(p.pos_z, org_z, cs_z, NZ);
    if (ci < NX - 1 && cj < NY - 1 && ck < NZ - 1) begin
      a = wind_addr(ci, cj, ck);
      ax = wind_addr(ci + 1, cj, ck);
      ay = wind_addr(ci, cj + 1, ck);
      az = wind_addr(ci, cj, ck + 1);
      w = '0;
      w.func = FUNC_WRITE;
      for (int c = 0; c < 6; c++) begin
        w.index_i = ci + (c == 3); w.index_j = cj + (c == 4); w.index_k = ck + (c == 5);
        w.component = (c < 3) ? c[1:0] : c[1:0] - 2'd3;
        w.value = rand_wind();
        if ((w.component == COMP_X && !wind_x.exists(wind_addr(w.index_i, w.index_j,
             w.index_k))) ||
            (w.component == COMP_Y && !wind_y.exists(wind_addr(w.index_i, w.index_j,
             w.index_k))) ||
            (w.component == COMP_Z && !wind_z.exists(wind_addr(w.index_i, w.index_j,
             w.index_k))))
          issue(w);
      end
    end
  endtask

  task automatic push_particle(pad_in_t p);
    fill_wind(p);
    issue(p);
  endtask

  function automatic longint place(longint org, longint cs, int lo, int hi);
    longint c, b;
    b = (cs == 0) ? 1 : cs;
    c = $signed($urandom_range(hi - lo)) + lo;
    return clamp_pos(org + c * b + longint'($urandom) % b);
  endfunction

  function automatic pad_in_t rand_particle();
    pad_in_t p;
    p = '0;
    p.func = FUNC_PUSH;
    p.index_i = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
    p.index_j = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
    p.index_k = $urandom;
    p.component = $urandom;
    p.value = $urandom;
    p.mass = $urandom;
    p.settle_speed = ($urandom_range(3) == 0) ? $urandom : $urandom_range(65536);
    if ($urandom_range(9) == 0) begin
      p.pos_x = {$urandom, $urandom};
      p.pos_y = {$urandom, $urandom};
      p.pos_z = {$urandom, $urandom};
    end else begin
      p.pos_x = place(org_x, cs_x, -1, 5);
      p.pos_y = place(org_y, cs_y, -1, 5);
      p.pos_z = place(org_z, cs_z, 0, 3);
    end
    return p;
  endfunction

  // Wait for every expected word, then let the block settle.
  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid_i && expected_words.size() == 0);
    repeat (80) @(negedge clk_i);
  endtask

  // Write all registers and mirror them in the predictor.
  task automatic set_regs(longint ox, longint oy, longint oz, longint cx, longint cy,
                          longint cz, longint ts);
    longint vals [7];
    vals = '{ox, oy, oz, cx, cy, cz, ts};
    org_x = longint'($signed(vals[0][39:0]));
    org_y = longint'($signed(vals[1][39:0]));
    org_z = longint'($signed(vals[2][39:0]));
    cs_x = vals[3] & 64'hFFFF_FFFF;
    cs_y = vals[4] & 64'hFFFF_FFFF;
    cs_z = vals[5] & 64'hFFFF_FFFF;
    dt = vals[6] & 64'hFF_FFFF;
    for (int r = 0; r < 7; r++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= r[CFG_IDX_W-1:0];
      cfg_data_i <= vals[r][CFG_DATA_W-1:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drive the input channel: advance on acceptance, idle at random.
  always @(posedge clk_i) in_taken <= in_valid_i && !in_stall_o;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
        in_valid_i <= 1'b1;
        in_item_i <= pending_words.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= !calm && $urandom_range(99) < 31;
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    pad_out_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("result word with no expectation: %h", out_item_o);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_item_o.new_x !== exp_w.new_x) begin
          $error("new_x expected %0d got %0d", exp_w.new_x, out_item_o.new_x);
          errors++;
        end
        if (out_item_o.new_y !== exp_w.new_y) begin
          $error("new_y expected %0d got %0d", exp_w.new_y, out_item_o.new_y);
          errors++;
        end
        if (out_item_o.new_z !== exp_w.new_z) begin
          $error("new_z expected %0d got %0d", exp_w.new_z, out_item_o.new_z);
          errors++;
        end
        if (out_item_o.deposited !== exp_w.deposited) begin
          $error("deposited expected %0d got %0d", exp_w.deposited, out_item_o.deposited);
          errors++;
        end
        if (out_item_o.map_value !== exp_w.map_value) begin
          $error("map_value expected %0d got %0d", exp_w.map_value, out_item_o.map_value);
          errors++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    pad_in_t w;
    org_x = 0; org_y = 0; org_z = 0;
    cs_x = 65536; cs_y = 65536; cs_z = 65536; dt = 65536;
    foreach (dep_map[m]) dep_map[m] = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme writes, ignored component, unused code, extreme positions.
    set_regs(0, 0, 0, 65536, 65536, 65536, 65536);
    w = '0;
    w.func = FUNC_WRITE; w.component = COMP_X; w.index_i = 63; w.index_j = 63;
    w.index_k = 31; w.value = 24'sh7FFFFF;
    issue(w);
    w.component = COMP_Z; w.value = 24'sh800000;
    issue(w);
    w.component = COMP_NONE; w.value = '1;
    issue(w);
    w = '1;
    w.func = FUNC_NOP;
    issue(w);
    w = '0;
    w.func = FUNC_PUSH; w.pos_x = POS_HI; w.pos_y = POS_HI; w.pos_z = POS_HI;
    w.mass = '1; w.settle_speed = '1; w.index_i = 63; w.index_j = 63;
    push_particle(w);
    w.pos_x = POS_LO; w.pos_y = POS_LO; w.pos_z = POS_LO;
    push_particle(w);
    w.pos_x = 65536; w.pos_y = 65536; w.pos_z = 1000; w.settle_speed = 65536;
    w.index_i = 1; w.index_j = 2; w.mass = 12345;
    push_particle(w);
    w.pos_z = 5 * 65536; w.settle_speed = 0;
    push_particle(w);
    w = '0;
    w.func = FUNC_READ; w.index_i = 63; w.index_j = 63;
    issue(w);
    w.index_i = 1; w.index_j = 2;
    issue(w);
    w.index_i = 0; w.index_j = 0;
    issue(w);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(0, 0, 0, 65536, 65536, 65536, 65536);
        1: set_regs($signed($urandom_range(200000)) - 100000, $urandom_range(50000),
                    -$signed($urandom_range(50000)), $urandom_range(20000, 200000),
                    $urandom_range(20000, 200000), $urandom_range(20000, 200000),
                    $urandom_range(1000, 40000));
        2: set_regs(POS_HI, POS_LO, POS_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    24'hFF_FFFF);
        3: set_regs(POS_LO, POS_HI, POS_LO, 0, 1, 0, 0);
        4: set_regs(-40'sd65536, 40'sd32768, 40'sd12345, 1, 32'hFFFF_FFFF, 65536,
                    24'hFF_FFFF);
        default: set_regs($signed({$urandom, $urandom}) >>> 30,
                          $signed({$urandom, $urandom}) >>> 30,
                          $signed({$urandom, $urandom}) >>> 30,
                          $urandom_range(1, 300000), $urandom_range(1, 300000),
                          $urandom_range(1, 300000), $urandom);
      endcase
      calm = (ph == 2);
      for (int n = 0; n < 30; n++) begin
        case ($urandom_range(9))
          0, 1: begin
            w = '0;
            w.func = FUNC_WRITE; w.component = $urandom_range(3);
            w.index_i = $urandom; w.index_j = $urandom; w.index_k = $urandom;
            w.value = rand_wind();
            w.pos_x = {$urandom, $urandom}; w.mass = $urandom;
            issue(w);
          end
          2, 3: begin
            w = '0;
            w.func = FUNC_READ;
            w.index_i = ($urandom_range(1) == 0) ? $urandom : $urandom_range(7);
            w.index_j = ($urandom_range(1) == 0) ? $urandom : $urandom_range(7);
            issue(w);
          end
          4: begin
            w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom};
            w.func = FUNC_NOP;
            issue(w);
          end
          default: push_particle(rand_particle());
        endcase
      end
      // Hold the sender until every result has arrived.
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("particle_advect_deposit verification clean");
    end else begin
      $display("particle_advect_deposit verification failed");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #40ms;
    $display("particle_advect_deposit verification failed");
    $finish;
  end

endmodule
